/* sv/sis_pkg.sv */
package sis_pkg;

  // Default number of stack entries.
  localparam int DEPTH_DEF = 16;

  // Fixed payload widths.
  localparam int WORD_W = 32;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [REQ_W-1:0]         req_t;
  typedef logic [STAT_W-1:0]        stat_t;
  typedef logic [FILL_W-1:0]        fill_t;

  // Request codes.
  localparam req_t REQ_PUSH   = 2'd0;
  localparam req_t REQ_POP    = 2'd1;
  localparam req_t REQ_INSERT = 2'd2;

  // Status codes.
  localparam stat_t ST_OK        = 2'd0;
  localparam stat_t ST_OVERFLOW  = 2'd1;
  localparam stat_t ST_UNDERFLOW = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_INSERT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    word_t     value;
  } cell_ctrl_t;

endpackage

/* sv/sis_if.sv */
// Request channel: one stack operation per transaction.
interface sis_req_if
  import sis_pkg::*;
();
  logic  valid;
  logic  ready;
  req_t  req_type;
  word_t data_value;

  modport source (output valid, req_type, data_value, input ready);
  modport sink   (input valid, req_type, data_value, output ready);
endinterface

// Response channel: one stack report per transaction.
interface sis_rsp_if
  import sis_pkg::*;
();
  logic  valid;
  logic  ready;
  stat_t status;
  word_t popped_value;
  word_t top_value;
  word_t middle_value;
  fill_t fill_count;
  logic  is_sorted;

  modport source (output valid, status, popped_value, top_value, middle_value,
                  fill_count, is_sorted, input ready);
  modport sink   (input valid, status, popped_value, top_value, middle_value,
                  fill_count, is_sorted, output ready);
endinterface

/* sv/sis_cell.sv */
// One stack slot. Cell 0 is the top; data moves one cell down on a push
// (on an insert, from the insert point on) and one cell up on a pop.
module sis_cell
  import sis_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       valid,
  input  word_t      above_data,
  input  word_t      below_data,
  input  logic       below_valid,
  input  logic       found_in,
  output logic       found_out,
  output word_t      data,
  output logic       order_ok
);

  word_t data_r;
  word_t data_nxt;
  logic  hit;

  // The insert point is the first slot from the top that is empty or holds
  // a value not smaller than the new one; a push always hits at the top.
  assign hit       = (ctrl.cmd == CELL_PUSH) || !valid || (data_r >= ctrl.value);
  assign found_out = found_in || hit;

  // Slot update for the broadcast command.
  always_comb begin
    data_nxt = data_r;
    case (ctrl.cmd)
      CELL_PUSH, CELL_INSERT: begin
        if (found_in) begin
          data_nxt = above_data;
        end else if (hit) begin
          data_nxt = ctrl.value;
        end
      end
      CELL_POP: begin
        data_nxt = below_data;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Order between this slot and the one below it.
  assign order_ok = !(valid && below_valid) || (below_data >= data_r);
  assign data     = data_r;

endmodule

/* sv/sorted_insert_stack.sv */
// Bounded stack of signed 32-bit words with plain push, pop and sorted insert.
// Requests arrive on in_chan (req_type, data_value) and every accepted
// transaction produces exactly one report on out_chan: status, popped value,
// top value, middle value (entry count/2 below the top), fill count and a
// flag that is set when the entries are non-decreasing from top to bottom.
// The entries live in a chain of DEPTH cells; all cells compare against the
// new value at once and shift toward or away from the top together.
// The request updates the cells and the status registers, and the report
// register then loads from the updated cells once out_chan can take it;
// in_chan is not ready again until that report has been loaded.
// A new request is accepted while the previous report still waits in the
// output register; the report of that request is then held until out_chan
// drains, and in_chan stays stalled meanwhile.
// A full stack drops push and insert with overflow status; a pop on an empty
// stack reports underflow and leaves the stack unchanged. Request code 3 is
// a no-op that still reports. Synchronous reset empties the stack at once.
module sorted_insert_stack
  import sis_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sis_req_if.sink   in_chan,
  sis_rsp_if.source out_chan
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [CW-1:0] count_r, count_nxt;
  logic          calc_r;
  stat_t         stat_r, stat_nxt;
  word_t         popped_r, popped_nxt;
  cell_ctrl_t    ctrl;
  logic          accept;
  logic          load_out;

  word_t         cell_data [DEPTH];
  logic          cell_valid [DEPTH];
  logic          cell_order [DEPTH];
  logic [DEPTH:0] found;

  logic          out_valid_r;
  stat_t         out_status_r;
  word_t         out_popped_r, out_top_r, out_mid_r;
  fill_t         out_fill_r;
  logic          out_sorted_r;
  logic [IW-1:0] mid_idx;
  logic          sorted_all;

  assign in_chan.ready = !calc_r;
  assign accept        = in_chan.valid && !calc_r;
  assign load_out      = calc_r && (!out_valid_r || out_chan.ready);

  // Decode the request into a cell command, status and new count.
  always_comb begin
    ctrl.cmd   = CELL_HOLD;
    ctrl.value = in_chan.data_value;
    count_nxt  = count_r;
    stat_nxt   = ST_OK;
    popped_nxt = '0;
    if (accept) begin
      case (in_chan.req_type)
        REQ_PUSH, REQ_INSERT: begin
          if (count_r == FULL) begin
            stat_nxt = ST_OVERFLOW;
          end else begin
            ctrl.cmd  = (in_chan.req_type == REQ_PUSH) ? CELL_PUSH : CELL_INSERT;
            count_nxt = count_r + 1'b1;
          end
        end
        REQ_POP: begin
          if (count_r == '0) begin
            stat_nxt = ST_UNDERFLOW;
          end else begin
            ctrl.cmd   = CELL_POP;
            count_nxt  = count_r - 1'b1;
            popped_nxt = cell_data[0];
          end
        end
        default: begin
          ctrl.cmd = CELL_HOLD;
        end
      endcase
    end
  end

  // Chain of cells, top at index 0.
  assign found[0] = 1'b0;
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    assign cell_valid[k] = (CW'(k) < count_r);
    sis_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (cell_valid[k]),
      .above_data  ((k == 0) ? ctrl.value : cell_data[(k == 0) ? 0 : k-1]),
      .below_data  ((k == DEPTH-1) ? word_t'(0) : cell_data[(k == DEPTH-1) ? k : k+1]),
      .below_valid ((k == DEPTH-1) ? 1'b0 : cell_valid[(k == DEPTH-1) ? k : k+1]),
      .found_in    (found[k]),
      .found_out   (found[k+1]),
      .data        (cell_data[k]),
      .order_ok    (cell_order[k])
    );
  end

  // Report values from the updated cells.
  assign mid_idx = IW'(count_r >> 1);
  always_comb begin
    sorted_all = 1'b1;
    for (int k = 0; k < DEPTH; k++) begin
      sorted_all = sorted_all & cell_order[k];
    end
  end

  // Control state and request bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      calc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        calc_r <= 1'b1;
      end else if (load_out) begin
        calc_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      stat_r   <= stat_nxt;
      popped_r <= popped_nxt;
    end
    if (load_out) begin
      out_status_r <= stat_r;
      out_popped_r <= popped_r;
      out_top_r    <= (count_r == '0) ? word_t'(0) : cell_data[0];
      out_mid_r    <= (count_r == '0) ? word_t'(0) : cell_data[mid_idx];
      out_fill_r   <= FILL_W'(count_r);
      out_sorted_r <= sorted_all;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.popped_value = out_popped_r;
  assign out_chan.top_value    = out_top_r;
  assign out_chan.middle_value = out_mid_r;
  assign out_chan.fill_count   = out_fill_r;
  assign out_chan.is_sorted    = out_sorted_r;

endmodule

/* sv/sis_checker.sv */
// Port-level checks on the stack reports.
module sis_checker
  import sis_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic  clk,
  input logic  rst_n,
  input logic  out_valid,
  input logic  out_ready,
  input stat_t status,
  input word_t popped_value,
  input word_t top_value,
  input word_t middle_value,
  input fill_t fill_count,
  input logic  is_sorted
);

  // A stalled report stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("report withdrawn while stalled");

  // An empty stack reports zeros and counts as sorted.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (fill_count == '0) |->
      (top_value == '0) && (middle_value == '0) && is_sorted)
    else $error("empty stack report not clean");

  // Underflow leaves an empty stack and pops nothing.
  a_under: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_UNDERFLOW) |->
      (fill_count == '0) && (popped_value == '0))
    else $error("underflow report inconsistent");

  // Overflow only happens on a full stack and pops nothing.
  a_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_OVERFLOW) |->
      (fill_count == FILL_W'(DEPTH)) && (popped_value == '0))
    else $error("overflow report inconsistent");

  // With a single entry the middle is the top.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (fill_count == FILL_W'(1)) |-> (middle_value == top_value))
    else $error("single entry middle differs from top");

endmodule

bind sorted_insert_stack sis_checker #(.DEPTH(DEPTH)) u_sis_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .status       (out_chan.status),
  .popped_value (out_chan.popped_value),
  .top_value    (out_chan.top_value),
  .middle_value (out_chan.middle_value),
  .fill_count   (out_chan.fill_count),
  .is_sorted    (out_chan.is_sorted)
);
